@@ src/mwtk_pkg.sv @@
// ============================================================================
// mwtk_pkg
// Shared types and constants of the motif-window top-k scorer.
// ============================================================================
package mwtk_pkg;

    localparam int unsigned LOC_W   = 16;
    localparam int unsigned VAL_W   = 16;
    localparam int unsigned MOT_W   = 4;
    localparam int unsigned SCORE_W = 20;
    localparam int unsigned BITS_W  = 16;
    localparam int unsigned SLOT_W  = 3;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned CDAT_W  = 16;
    localparam int unsigned WT_W    = 15;
    localparam int unsigned POS_W   = 18;

    localparam logic [CIDX_W-1:0] CFG_WINDOW_STEP = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_WINDOW_SIZE = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_SEQ_LENGTH  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_NUM_BEST    = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_NUM_MOTIFS  = 3'd4;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef struct packed {
        logic                    cmd;
        logic [MOT_W-1:0]        motif_index;
        logic [LOC_W-1:0]        location;
        logic signed [VAL_W-1:0] hit_score;
    } t_in_beat;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [LOC_W-1:0]   window_begin;
        logic [SCORE_W-1:0] window_score;
        logic [BITS_W-1:0]  motif_bits;
        logic               overflow;
        logic               last;
    } t_out_beat;

    typedef struct packed {
        logic [MOT_W-1:0]        motif;
        logic [LOC_W-1:0]        location;
        logic signed [VAL_W-1:0] value;
    } t_hit;

    typedef struct packed {
        logic            hit;
        logic [WT_W-1:0] weight;
    } t_hit_eval;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OPEN,
        ST_HITS,
        ST_SUM,
        ST_PLACE,
        ST_SCAN,
        ST_NEXT,
        ST_EMIT
    } t_state;

endpackage

@@ src/mwtk_ram.sv @@
// ============================================================================
// mwtk_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module mwtk_ram #(
    parameter int unsigned WIDTH = 36,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/mwtk_hit_unit.sv @@
// ============================================================================
// mwtk_hit_unit
// Overlap and weight of one stored hit against the current window.
// ============================================================================
module mwtk_hit_unit #(
    parameter int unsigned MOTIF_LEN = 8
) (
    input  mwtk_pkg::t_hit                     i_hit,
    input  logic signed [mwtk_pkg::POS_W-1:0]  i_wb,
    input  logic signed [mwtk_pkg::POS_W-1:0]  i_we,
    output mwtk_pkg::t_hit_eval                o_eval
);
    import mwtk_pkg::*;

    localparam int unsigned BW = $clog2(MOTIF_LEN + 1);
    localparam int unsigned PW = BW + WT_W;

    logic signed [POS_W-1:0] loc, ie, d, e;
    logic [BW-1:0]           bases;
    logic [PW-1:0]           prod;

    always_comb begin
        loc   = signed'({2'b00, i_hit.location});
        ie    = loc + POS_W'(MOTIF_LEN - 1);
        d     = i_wb - loc;
        e     = ie - i_we;
        if (loc < i_wb) begin
            bases = (d >= POS_W'(MOTIF_LEN)) ? '0 : BW'(POS_W'(MOTIF_LEN) - d);
        end else if (ie > i_we) begin
            bases = (e >= POS_W'(MOTIF_LEN)) ? '0 : BW'(POS_W'(MOTIF_LEN) - e);
        end else begin
            bases = BW'(MOTIF_LEN);
        end
        prod          = PW'(bases) * PW'(i_hit.value[WT_W-1:0]);
        o_eval.hit    = (bases != '0) && !i_hit.value[VAL_W-1] && (i_hit.value != '0);
        o_eval.weight = WT_W'(prod / MOTIF_LEN);
    end
endmodule

@@ src/motif_window_top_k_scorer_core.sv @@
// ============================================================================
// motif_window_top_k_scorer_core
// Collects motif hits of one sequence and reports the best scoring windows.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall, payload i_in_data): a beat with
//   cmd = load stores one hit, one beat per cycle while idle. A full hit store
//   drops the hit and raises the overflow flag. A beat with cmd = end starts
//   the scan; o_in_stall stays high until every slot beat has been loaded
//   into the output register.
//   Config channel (i_cfg_valid / o_cfg_ready): always ready; the user must
//   write it only while idle, as the block itself does not enforce this.
//   Output channel (o_out_valid / i_out_stall): num_best beats (0 taken as 1,
//   capped at MAX_BEST), one per slot, last set on the final one. A stall
//   simply holds the output register and the slot sequencer waits.
//   After the end command, each window runs an open step, a pass over the
//   hits through the shared hit unit (one RAM read per hit), summing over
//   num_motifs, one place step, a minimum rescan of the slots when a window
//   replaces a slot, then one next-window step; windows = seq_length /
//   window_step. Then num_best output beats; loading the last one also empties
//   the store and the slots, so the next load beat is taken the cycle after.
//   Reset (synchronous, active low) restores the register defaults and
//   empties the hit store and the slots; hit RAM contents are not cleared.
// ============================================================================
module motif_window_top_k_scorer_core #(
    parameter int unsigned MAX_HITS   = 256,
    parameter int unsigned MAX_BEST   = 8,
    parameter int unsigned MAX_MOTIFS = 16,
    parameter int unsigned MOTIF_LEN  = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  mwtk_pkg::t_in_beat                    i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output mwtk_pkg::t_out_beat                   o_out_data,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mwtk_pkg::CIDX_W-1:0]           i_cfg_index,
    input  logic [mwtk_pkg::CDAT_W-1:0]           i_cfg_data
);
    import mwtk_pkg::*;

    localparam int unsigned AW  = $clog2(MAX_HITS);
    localparam int unsigned CW  = $clog2(MAX_HITS + 1);
    localparam int unsigned BW  = $clog2(MAX_BEST + 1);
    localparam int unsigned SW  = (MAX_BEST > 1) ? $clog2(MAX_BEST) : 1;
    localparam int unsigned NW  = $clog2(MAX_MOTIFS + 1);
    localparam int unsigned MW  = (MAX_MOTIFS > 1) ? $clog2(MAX_MOTIFS) : 1;
    localparam int unsigned HW  = $bits(t_hit);

    // configuration
    logic [15:0] r_step, r_size, r_len;
    logic [3:0]  r_num_best;
    logic [4:0]  r_num_motifs;

    // sequence state
    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic             r_drop, n_drop;
    logic [CW-1:0]    r_h, n_h;
    logic             r_pend, n_pend;
    logic [LOC_W-1:0] r_wb, n_wb;
    logic [WT_W-1:0]  r_best_hit [MAX_MOTIFS];
    logic [WT_W-1:0]  n_best_hit [MAX_MOTIFS];
    logic [BITS_W-1:0] r_bits, n_bits;
    logic [NW-1:0]    r_m, n_m;
    logic [SCORE_W-1:0] r_acc, n_acc;
    logic [LOC_W-1:0]   r_sl_begin [MAX_BEST];
    logic [LOC_W-1:0]   n_sl_begin [MAX_BEST];
    logic [SCORE_W-1:0] r_sl_score [MAX_BEST];
    logic [SCORE_W-1:0] n_sl_score [MAX_BEST];
    logic [BITS_W-1:0]  r_sl_bits  [MAX_BEST];
    logic [BITS_W-1:0]  n_sl_bits  [MAX_BEST];
    logic [SW-1:0]    r_min, n_min;
    logic [BW-1:0]    r_fill, n_fill;
    logic [BW-1:0]    r_n, n_n;
    logic [BW-1:0]    r_k, n_k;
    logic             r_out_valid, n_out_valid;
    t_out_beat        r_out, n_out;

    // derived values
    logic [BW-1:0]          nb;
    logic [NW-1:0]          nm;
    logic [15:0]            step;
    logic signed [POS_W-1:0] wb_s, we_s;
    logic                   in_acc, ram_we, out_free;
    logic [AW-1:0]          raddr;
    t_hit                   wr_hit, rd_hit;
    t_hit_eval              eval;
    logic [7:0]             mi_ext;
    logic [MW-1:0]          mi;
    logic [SCORE_W:0]       sum;
    logic [POS_W-1:0]       nxt_end;
    logic [7:0]             k_ext;

    always_comb begin
        if (r_num_best == '0) begin
            nb = BW'(1);
        end else if (32'(r_num_best) > MAX_BEST) begin
            nb = BW'(MAX_BEST);
        end else begin
            nb = BW'(r_num_best);
        end
        nm   = (32'(r_num_motifs) > MAX_MOTIFS) ? NW'(MAX_MOTIFS) : NW'(r_num_motifs);
        step = (r_step == '0) ? 16'd1 : r_step;
    end

    assign wb_s = signed'({2'b00, r_wb});
    assign we_s = wb_s + signed'({2'b00, r_size}) - POS_W'(1);

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign ram_we        = in_acc && (i_in_data.cmd == CMD_LOAD) && (32'(r_count) < MAX_HITS);
    assign wr_hit.motif    = i_in_data.motif_index;
    assign wr_hit.location = i_in_data.location;
    assign wr_hit.value    = i_in_data.hit_score;

    mwtk_ram #(
        .WIDTH (HW),
        .DEPTH (MAX_HITS)
    ) u_hit_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (wr_hit),
        .i_raddr (raddr),
        .o_rdata (rd_hit)
    );

    mwtk_hit_unit #(
        .MOTIF_LEN (MOTIF_LEN)
    ) u_hit_unit (
        .i_hit  (rd_hit),
        .i_wb   (wb_s),
        .i_we   (we_s),
        .o_eval (eval)
    );

    assign mi_ext = 8'(rd_hit.motif);
    assign mi     = mi_ext[MW-1:0];

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_drop      = r_drop;
        n_h         = r_h;
        n_pend      = r_pend;
        n_wb        = r_wb;
        n_best_hit  = r_best_hit;
        n_bits      = r_bits;
        n_m         = r_m;
        n_acc       = r_acc;
        n_sl_begin  = r_sl_begin;
        n_sl_score  = r_sl_score;
        n_sl_bits   = r_sl_bits;
        n_min       = r_min;
        n_fill      = r_fill;
        n_n         = r_n;
        n_k         = r_k;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        raddr       = r_h[AW-1:0];
        sum         = {1'b0, r_acc} + (SCORE_W + 1)'(r_best_hit[r_m[MW-1:0]]);
        nxt_end     = POS_W'(r_wb) + POS_W'(step) + POS_W'(step);
        k_ext       = 8'(r_k);

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.cmd == CMD_LOAD) begin
                        if (ram_we) begin
                            n_count = r_count + CW'(1);
                        end else begin
                            n_drop = 1'b1;
                        end
                    end else begin
                        n_wb    = '0;
                        n_k     = '0;
                        n_state = (step <= r_len) ? ST_OPEN : ST_EMIT;
                    end
                end
            end
            ST_OPEN: begin
                for (int i = 0; i < MAX_MOTIFS; i++) begin
                    n_best_hit[i] = '0;
                end
                n_bits  = '0;
                n_h     = '0;
                n_pend  = 1'b0;
                n_state = ST_HITS;
            end
            ST_HITS: begin
                if (r_h < r_count) begin
                    n_h    = r_h + CW'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend && eval.hit && (NW'(rd_hit.motif) < nm)) begin
                    n_bits[rd_hit.motif] = 1'b1;
                    if (eval.weight > r_best_hit[mi]) begin
                        n_best_hit[mi] = eval.weight;
                    end
                end
                if ((r_h == r_count) && !r_pend) begin
                    n_m     = '0;
                    n_acc   = '0;
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (r_m < nm) begin
                    n_acc = sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];
                    n_m   = r_m + NW'(1);
                end else begin
                    n_state = ST_PLACE;
                end
            end
            ST_PLACE: begin
                if (r_fill < nb) begin
                    n_sl_begin[r_fill[SW-1:0]] = r_wb;
                    n_sl_score[r_fill[SW-1:0]] = r_acc;
                    n_sl_bits[r_fill[SW-1:0]]  = r_bits;
                    if (r_acc <= r_sl_score[r_min]) begin
                        n_min = r_fill[SW-1:0];
                    end
                    n_fill  = r_fill + BW'(1);
                    n_state = ST_NEXT;
                end else if (r_acc > r_sl_score[r_min]) begin
                    n_sl_begin[r_min] = r_wb;
                    n_sl_score[r_min] = r_acc;
                    n_sl_bits[r_min]  = r_bits;
                    n_n     = '0;
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_NEXT;
                end
            end
            ST_SCAN: begin
                if (r_n < nb) begin
                    if (r_sl_score[r_n[SW-1:0]] < r_sl_score[r_min]) begin
                        n_min = r_n[SW-1:0];
                    end
                    n_n = r_n + BW'(1);
                end else begin
                    n_state = ST_NEXT;
                end
            end
            ST_NEXT: begin
                n_wb    = r_wb + step;
                n_state = (nxt_end <= POS_W'(r_len)) ? ST_OPEN : ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.slot         = k_ext[SLOT_W-1:0];
                    n_out.window_begin = r_sl_begin[r_k[SW-1:0]];
                    n_out.window_score = r_sl_score[r_k[SW-1:0]];
                    n_out.motif_bits   = r_sl_bits[r_k[SW-1:0]];
                    n_out.overflow     = r_drop;
                    n_out.last         = (r_k + BW'(1) == nb);
                    n_k                = r_k + BW'(1);
                    if (r_k + BW'(1) == nb) begin
                        // sequence done: empty the store and the slots
                        n_count = '0;
                        n_drop  = 1'b0;
                        n_min   = '0;
                        n_fill  = '0;
                        for (int i = 0; i < MAX_BEST; i++) begin
                            n_sl_begin[i] = '0;
                            n_sl_score[i] = '0;
                            n_sl_bits[i]  = '0;
                        end
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_h         <= '0;
            r_pend      <= 1'b0;
            r_min       <= '0;
            r_fill      <= '0;
            r_n         <= '0;
            r_k         <= '0;
            r_m         <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_BEST; i++) begin
                r_sl_begin[i] <= '0;
                r_sl_score[i] <= '0;
                r_sl_bits[i]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_drop      <= n_drop;
            r_h         <= n_h;
            r_pend      <= n_pend;
            r_min       <= n_min;
            r_fill      <= n_fill;
            r_n         <= n_n;
            r_k         <= n_k;
            r_m         <= n_m;
            r_out_valid <= n_out_valid;
            r_sl_begin  <= n_sl_begin;
            r_sl_score  <= n_sl_score;
            r_sl_bits   <= n_sl_bits;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_wb       <= n_wb;
        r_best_hit <= n_best_hit;
        r_bits     <= n_bits;
        r_acc      <= n_acc;
        r_out      <= n_out;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= 16'd1;
            r_size       <= 16'd1;
            r_len        <= 16'd0;
            r_num_best   <= 4'd1;
            r_num_motifs <= 5'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WINDOW_STEP: r_step       <= i_cfg_data;
                CFG_WINDOW_SIZE: r_size       <= i_cfg_data;
                CFG_SEQ_LENGTH:  r_len        <= i_cfg_data;
                CFG_NUM_BEST:    r_num_best   <= i_cfg_data[3:0];
                CFG_NUM_MOTIFS:  r_num_motifs <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule
